@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/pbrs_pkg.sv @@
// Shared constants, codes and control structs of the batch request scheduler
`default_nettype none
package pbrs_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 7;
  localparam int PRIO_W   = 2;
  localparam int TIME_W   = 48;
  localparam int PLEN_W   = 16;
  localparam int LIMIT_W  = 7;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;
  localparam int BUDGET_W = 24;
  localparam int ADMIT_W  = 7;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;
  localparam int ESTATE_W = 2;

  // most picks in one batch and the id buffer that holds them
  localparam int MAX_PICKS = 64;
  localparam int PICK_AW   = 6;

  localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BATCH    = 2'd3;

  localparam logic [STATUS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STS_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] STS_REFUSED = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL    = 2'd3;

  localparam logic [ESTATE_W-1:0] ES_PENDING   = 2'd0;
  localparam logic [ESTATE_W-1:0] ES_RUNNING   = 2'd1;
  localparam logic [ESTATE_W-1:0] ES_COMPLETED = 2'd2;
  localparam logic [ESTATE_W-1:0] ES_CANCELLED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONT   = 2'd2;

  localparam logic [BUDGET_W-1:0] BUDGET_RST = 24'd4096;
  localparam logic [ADMIT_W-1:0]  ADMIT_RST  = 7'd32;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic do_add;
    logic look_rd;
    logic do_update;
    logic batch_init;
    logic scan_init;
    logic scan_step;
    logic pick;
    logic load_empty;
    logic emit_rd;
    logic emit_ld;
  } pbrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic             in_fire;
    logic [CMD_W-1:0] in_cmd;
    logic             limit_zero;
    logic             scan_done;
    logic             pick_ok;
    logic             pick_final;
    logic             sel_zero;
    logic             out_valid;
    logic             emit_done;
  } pbrs_stat_t;

endpackage
`default_nettype wire

@@ rtl/core/pbrs_if.sv @@
// Command and response channel interfaces
`default_nettype none
interface pbrs_req_if;
  logic                           valid;
  logic                           ready;
  logic [pbrs_pkg::CMD_W-1:0]     cmd;
  logic [pbrs_pkg::ID_W-1:0]      req_id;
  logic [pbrs_pkg::PRIO_W-1:0]    priority_req;
  logic [pbrs_pkg::TIME_W-1:0]    created_time;
  logic [pbrs_pkg::PLEN_W-1:0]    prompt_length;
  logic [pbrs_pkg::LIMIT_W-1:0]   batch_limit;

  modport source (output valid, cmd, req_id, priority_req, created_time, prompt_length,
                  batch_limit, input ready);
  modport sink (input valid, cmd, req_id, priority_req, created_time, prompt_length,
                batch_limit, output ready);
endinterface

interface pbrs_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pbrs_pkg::STATUS_W-1:0]  status_code;
  logic [pbrs_pkg::ID_W-1:0]      result_id;
  logic                           id_valid;
  logic                           last;
  logic [pbrs_pkg::TOTAL_W-1:0]   pending_total;
  logic [pbrs_pkg::TOTAL_W-1:0]   running_total;
  logic [pbrs_pkg::TOTAL_W-1:0]   completed_total;

  modport source (output valid, status_code, result_id, id_valid, last, pending_total,
                  running_total, completed_total, input ready);
  modport sink (input valid, status_code, result_id, id_valid, last, pending_total,
                running_total, completed_total, output ready);
endinterface
`default_nettype wire

@@ rtl/core/pbrs_ctrl.sv @@
// Command sequencer of the batch request scheduler
`default_nettype none
`include "assert_macros.svh"
module pbrs_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  pbrs_pkg::pbrs_stat_t stat,
  output pbrs_pkg::pbrs_cmd_t  ctl
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_LOOK   = 4'd2;
  localparam logic [3:0] S_UPD    = 4'd3;
  localparam logic [3:0] S_RESP   = 4'd4;
  localparam logic [3:0] S_BSTART = 4'd5;
  localparam logic [3:0] S_SINIT  = 4'd6;
  localparam logic [3:0] S_SCAN   = 4'd7;
  localparam logic [3:0] S_PICK   = 4'd8;
  localparam logic [3:0] S_ERD    = 4'd9;
  localparam logic [3:0] S_ELD    = 4'd10;
  localparam logic [3:0] S_EWAIT  = 4'd11;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        ctl.in_ready = 1'b1;
        if (stat.in_fire) begin
          unique case (stat.in_cmd)
            pbrs_pkg::CMD_ADD:      state_next = S_ADD;
            pbrs_pkg::CMD_CANCEL,
            pbrs_pkg::CMD_COMPLETE: state_next = S_LOOK;
            pbrs_pkg::CMD_BATCH:    state_next = S_BSTART;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        ctl.do_add = 1'b1;
        state_next = S_RESP;
      end
      S_LOOK: begin
        ctl.look_rd = 1'b1;
        state_next = S_UPD;
      end
      S_UPD: begin
        ctl.do_update = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!stat.out_valid) state_next = S_IDLE;
      end
      S_BSTART: begin
        ctl.batch_init = 1'b1;
        if (stat.limit_zero) begin
          ctl.load_empty = 1'b1;
          state_next = S_RESP;
        end else begin
          state_next = S_SINIT;
        end
      end
      S_SINIT: begin
        ctl.scan_init = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_done) state_next = S_PICK;
      end
      S_PICK: begin
        if (stat.pick_ok) begin
          ctl.pick = 1'b1;
          state_next = stat.pick_final ? S_ERD : S_SINIT;
        end else if (stat.sel_zero) begin
          ctl.load_empty = 1'b1;
          state_next = S_RESP;
        end else begin
          state_next = S_ERD;
        end
      end
      S_ERD: begin
        ctl.emit_rd = 1'b1;
        state_next = S_ELD;
      end
      S_ELD: begin
        ctl.emit_ld = 1'b1;
        state_next = S_EWAIT;
      end
      S_EWAIT: begin
        if (!stat.out_valid) state_next = stat.emit_done ? S_IDLE : S_ERD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  `ASSERT_ON(a_out_only_in_wait, !stat.out_valid || state == S_RESP || state == S_EWAIT, "result held outside a wait state")
  `ASSERT_ON(a_fire_means_idle, !stat.in_fire || $past(state_next == S_IDLE) || state == S_IDLE, "command taken while busy")

endmodule
`default_nettype wire

@@ rtl/core/pbrs_dp.sv @@
// Request table, counters, scan unit, pick buffer and result register
`default_nettype none
`include "assert_macros.svh"
module pbrs_dp #(
  parameter int TABLE_DEPTH = pbrs_pkg::TABLE_DEPTH_DEF,
  parameter int LENGTH_BITS = pbrs_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pbrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbrs_pkg::CFG_W-1:0]     cfg_data,
  pbrs_req_if.sink                            req,
  pbrs_rsp_if.source                          rsp,
  input  pbrs_pkg::pbrs_cmd_t                 ctl,
  output pbrs_pkg::pbrs_stat_t                stat
);

  localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int MW   = (CW > pbrs_pkg::ID_W) ? CW : pbrs_pkg::ID_W;
  localparam int UW   = LENGTH_BITS + pbrs_pkg::LIMIT_W;
  localparam int BW   = ((UW > pbrs_pkg::BUDGET_W) ? UW : pbrs_pkg::BUDGET_W) + 1;
  localparam int SW   = CW + 2;

  // configuration
  logic [pbrs_pkg::BUDGET_W-1:0] token_budget;
  logic [pbrs_pkg::ADMIT_W-1:0]  admit_limit;
  logic                          continuous_batching;

  always_ff @(posedge clk) begin
    if (rst) begin
      token_budget        <= pbrs_pkg::BUDGET_RST;
      admit_limit         <= pbrs_pkg::ADMIT_RST;
      continuous_batching <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        pbrs_pkg::CFG_BUDGET: token_budget        <= cfg_data[pbrs_pkg::BUDGET_W-1:0];
        pbrs_pkg::CFG_ADMIT:  admit_limit         <= cfg_data[pbrs_pkg::ADMIT_W-1:0];
        pbrs_pkg::CFG_CONT:   continuous_batching <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // command capture
  logic                          in_fire;
  logic [pbrs_pkg::CMD_W-1:0]    cmd_q;
  logic [pbrs_pkg::ID_W-1:0]     req_id_q;
  logic [pbrs_pkg::PRIO_W-1:0]   prio_q;
  logic [pbrs_pkg::TIME_W-1:0]   time_q;
  logic [LENGTH_BITS-1:0]        len_q;
  logic [pbrs_pkg::LIMIT_W-1:0]  limit_q;

  assign req.ready = ctl.in_ready;
  assign in_fire   = req.valid && ctl.in_ready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q    <= req.cmd;
      req_id_q <= req.req_id;
      prio_q   <= req.priority_req;
      time_q   <= req.created_time;
      len_q    <= LENGTH_BITS'(req.prompt_length);
      limit_q  <= (req.batch_limit > pbrs_pkg::LIMIT_W'(pbrs_pkg::MAX_PICKS)) ?
                  pbrs_pkg::LIMIT_W'(pbrs_pkg::MAX_PICKS) : req.batch_limit;
    end
  end

  // counters
  logic [CW-1:0] entry_count, pending_count, running_count, completed_count;
  logic [CW-1:0] entry_count_next, pending_count_next, running_count_next;
  logic [CW-1:0] completed_count_next;
  logic [SW-1:0] state_sum;

  // request table
  logic [pbrs_pkg::ESTATE_W-1:0] state_mem [TABLE_DEPTH];
  logic [pbrs_pkg::PRIO_W-1:0]   prio_mem  [TABLE_DEPTH];
  logic [pbrs_pkg::TIME_W-1:0]   time_mem  [TABLE_DEPTH];
  logic [LENGTH_BITS-1:0]        len_mem   [TABLE_DEPTH];
  logic [pbrs_pkg::ESTATE_W-1:0] state_rd;
  logic [pbrs_pkg::PRIO_W-1:0]   prio_rd;
  logic [pbrs_pkg::TIME_W-1:0]   time_rd;
  logic [LENGTH_BITS-1:0]        len_rd;

  logic [AW-1:0]                 rd_addr, wr_addr, id_slot;
  logic                          st_we, add_we;
  logic [pbrs_pkg::ESTATE_W-1:0] st_wdata;

  // scan unit
  logic [CW-1:0] scan_idx;
  logic          rd_pend;
  logic [AW-1:0] rd_slot;
  logic          best_found;
  logic [AW-1:0] best_slot;
  logic [pbrs_pkg::PRIO_W-1:0] best_prio;
  logic [pbrs_pkg::TIME_W-1:0] best_time;
  logic [LENGTH_BITS-1:0]      best_len;
  logic          better;

  // batch state
  logic [pbrs_pkg::LIMIT_W-1:0] sel, emit_idx;
  logic [UW-1:0]                used;
  logic [BW-1:0]                used_sum;
  logic [pbrs_pkg::ID_W-1:0]    pick_buf [pbrs_pkg::MAX_PICKS];
  logic [pbrs_pkg::ID_W-1:0]    buf_rd;
  logic [pbrs_pkg::ID_W-1:0]    best_id;

  // add and update decisions
  logic id_ok, add_refuse, add_full, upd_change;
  logic [pbrs_pkg::ESTATE_W-1:0] target, other;
  logic [pbrs_pkg::STATUS_W-1:0] upd_status, add_status;

  assign id_slot = AW'(req_id_q - pbrs_pkg::ID_W'(1));
  assign id_ok   = (req_id_q != '0) && (MW'(req_id_q) <= MW'(entry_count));
  assign target  = (cmd_q == pbrs_pkg::CMD_CANCEL) ? pbrs_pkg::ES_CANCELLED
                                                   : pbrs_pkg::ES_COMPLETED;
  assign other   = (cmd_q == pbrs_pkg::CMD_CANCEL) ? pbrs_pkg::ES_COMPLETED
                                                   : pbrs_pkg::ES_CANCELLED;
  assign upd_change = id_ok && (state_rd != target) && (state_rd != other);
  assign upd_status = (!id_ok || state_rd == other) ? pbrs_pkg::STS_INVALID
                                                    : pbrs_pkg::STS_OK;

  assign add_refuse = !continuous_batching && (MW'(running_count) >= MW'(admit_limit));
  assign add_full   = (MW'(entry_count) >= MW'(TABLE_DEPTH));
  assign add_status = add_refuse ? pbrs_pkg::STS_REFUSED :
                      add_full   ? pbrs_pkg::STS_FULL : pbrs_pkg::STS_OK;

  assign best_id  = pbrs_pkg::ID_W'({1'b0, best_slot} + (AW+1)'(1));
  assign used_sum = BW'(used) + BW'(best_len);

  always_comb begin
    entry_count_next     = entry_count;
    pending_count_next   = pending_count;
    running_count_next   = running_count;
    completed_count_next = completed_count;
    st_we    = 1'b0;
    add_we   = 1'b0;
    st_wdata = pbrs_pkg::ES_PENDING;
    wr_addr  = entry_count[AW-1:0];
    if (ctl.do_add && add_status == pbrs_pkg::STS_OK) begin
      add_we = 1'b1;
      st_we  = 1'b1;
      entry_count_next   = entry_count + CW'(1);
      pending_count_next = pending_count + CW'(1);
    end
    if (ctl.do_update && upd_change) begin
      st_we    = 1'b1;
      st_wdata = target;
      wr_addr  = id_slot;
      if (state_rd == pbrs_pkg::ES_PENDING) pending_count_next = pending_count - CW'(1);
      if (state_rd == pbrs_pkg::ES_RUNNING && running_count != '0)
        running_count_next = running_count - CW'(1);
      if (cmd_q == pbrs_pkg::CMD_COMPLETE) completed_count_next = completed_count + CW'(1);
    end
    if (ctl.pick) begin
      st_we    = 1'b1;
      st_wdata = pbrs_pkg::ES_RUNNING;
      wr_addr  = best_slot;
      pending_count_next = pending_count - CW'(1);
      running_count_next = running_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      pending_count   <= '0;
      running_count   <= '0;
      completed_count <= '0;
    end else begin
      entry_count     <= entry_count_next;
      pending_count   <= pending_count_next;
      running_count   <= running_count_next;
      completed_count <= completed_count_next;
    end
  end

  assign state_sum = SW'(pending_count) + SW'(running_count) + SW'(completed_count);

  assign rd_addr = ctl.look_rd ? id_slot : scan_idx[AW-1:0];

  always_ff @(posedge clk) begin
    if (st_we) state_mem[wr_addr] <= st_wdata;
    if (add_we) begin
      prio_mem[wr_addr] <= prio_q;
      time_mem[wr_addr] <= time_q;
      len_mem[wr_addr]  <= len_q;
    end
    state_rd <= state_mem[rd_addr];
    prio_rd  <= prio_mem[rd_addr];
    time_rd  <= time_mem[rd_addr];
    len_rd   <= len_mem[rd_addr];
  end

  // one table entry enters the comparison each cycle; ties keep the lower slot
  assign better = (state_rd == pbrs_pkg::ES_PENDING) &&
                  (!best_found || prio_rd > best_prio ||
                   (prio_rd == best_prio && time_rd < best_time));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      scan_idx   <= '0;
    end else if (ctl.scan_init) begin
      rd_pend    <= 1'b0;
      best_found <= 1'b0;
      scan_idx   <= '0;
    end else if (ctl.scan_step) begin
      rd_pend <= (scan_idx < entry_count);
      rd_slot <= scan_idx[AW-1:0];
      if (scan_idx < entry_count) scan_idx <= scan_idx + CW'(1);
      if (rd_pend && better) begin
        best_found <= 1'b1;
        best_slot  <= rd_slot;
        best_prio  <= prio_rd;
        best_time  <= time_rd;
        best_len   <= len_rd;
      end
    end
  end

  // batch bookkeeping and id buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      sel      <= '0;
      emit_idx <= '0;
    end else begin
      if (ctl.batch_init) begin
        sel      <= '0;
        emit_idx <= '0;
        used     <= '0;
      end
      if (ctl.pick) begin
        sel  <= sel + pbrs_pkg::LIMIT_W'(1);
        used <= UW'(used_sum);
      end
      if (ctl.emit_ld) emit_idx <= emit_idx + pbrs_pkg::LIMIT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pick) pick_buf[sel[pbrs_pkg::PICK_AW-1:0]] <= best_id;
    if (ctl.emit_rd) buf_rd <= pick_buf[emit_idx[pbrs_pkg::PICK_AW-1:0]];
  end

  // result register
  logic                          out_valid;
  logic [pbrs_pkg::STATUS_W-1:0] out_status;
  logic [pbrs_pkg::ID_W-1:0]     out_id;
  logic                          out_idv, out_last;
  logic [pbrs_pkg::TOTAL_W-1:0]  out_pend, out_run, out_comp;
  logic                          load;

  assign load = ctl.do_add || ctl.do_update || ctl.load_empty || ctl.emit_ld;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (load) out_valid <= 1'b1;
    else if (rsp.ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_pend <= pbrs_pkg::TOTAL_W'(pending_count_next);
      out_run  <= pbrs_pkg::TOTAL_W'(running_count_next);
      out_comp <= pbrs_pkg::TOTAL_W'(completed_count_next);
      if (ctl.do_add) begin
        out_status <= add_status;
        out_id     <= (add_status == pbrs_pkg::STS_OK) ? pbrs_pkg::ID_W'(entry_count_next)
                                                       : '0;
        out_idv    <= (add_status == pbrs_pkg::STS_OK);
        out_last   <= 1'b1;
      end else if (ctl.do_update) begin
        out_status <= upd_status;
        out_id     <= '0;
        out_idv    <= 1'b0;
        out_last   <= 1'b1;
      end else if (ctl.emit_ld) begin
        out_status <= pbrs_pkg::STS_OK;
        out_id     <= buf_rd;
        out_idv    <= 1'b1;
        out_last   <= (emit_idx + pbrs_pkg::LIMIT_W'(1) == sel);
      end else begin
        out_status <= pbrs_pkg::STS_OK;
        out_id     <= '0;
        out_idv    <= 1'b0;
        out_last   <= 1'b1;
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status_code     = out_status;
  assign rsp.result_id       = out_id;
  assign rsp.id_valid        = out_idv;
  assign rsp.last            = out_last;
  assign rsp.pending_total   = out_pend;
  assign rsp.running_total   = out_run;
  assign rsp.completed_total = out_comp;

  assign stat.in_fire    = in_fire;
  assign stat.in_cmd     = req.cmd;
  assign stat.limit_zero = (limit_q == '0);
  assign stat.scan_done  = (scan_idx == entry_count) && !rd_pend;
  assign stat.pick_ok    = best_found && (sel == '0 || used_sum <= BW'(token_budget));
  assign stat.pick_final = (sel + pbrs_pkg::LIMIT_W'(1) == limit_q);
  assign stat.sel_zero   = (sel == '0);
  assign stat.out_valid  = out_valid;
  assign stat.emit_done  = (emit_idx == sel);

  `ASSERT_ON(a_count_sum, state_sum <= SW'(entry_count), "state counters exceed table fill")
  `ASSERT_ON(a_pick_pending, !ctl.pick || (best_found && pending_count != '0), "idle pick")

endmodule
`default_nettype wire

@@ rtl/core/priority_batch_request_scheduler_unit.sv @@
// Top level of the priority batch request scheduler
// Usage:
//   req carries one command per beat (add, cancel, complete, next batch);
//   a beat is taken when req.valid and req.ready are high at a clock edge.
//   rsp returns the result beats; rsp.last marks the final beat of a command.
//   cfg_we/cfg_index/cfg_data write token_budget (0), admit_limit (1) and
//   continuous_batching (2); write only while no command is in flight.
// Sequencing:
//   Commands are handled one at a time; req.ready is high only between
//   commands. Add loads its beat in S_ADD; cancel and complete read the
//   table (S_LOOK), then update it (S_UPD). Next batch runs one table scan
//   per selected request through the single read port of the request
//   table, then sends each beat from the pick buffer via the output register.
// Reset (rst, synchronous): table empty, counters zero, registers 4096, 32, 1.
// Stall: a result beat stays in the output register while rsp.ready is low,
//   and the scheduler holds until it is taken.
`default_nettype none
module priority_batch_request_scheduler_unit #(
  parameter int TABLE_DEPTH = pbrs_pkg::TABLE_DEPTH_DEF,
  parameter int LENGTH_BITS = pbrs_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [pbrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbrs_pkg::CFG_W-1:0]     cfg_data,
  pbrs_req_if.sink                            req,
  pbrs_rsp_if.source                          rsp
);

  pbrs_pkg::pbrs_cmd_t  ctl;
  pbrs_pkg::pbrs_stat_t stat;

  pbrs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  pbrs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp),
    .ctl       (ctl),
    .stat      (stat)
  );

endmodule
`default_nettype wire
